// ===== rtl/plb_pkg.sv =====
// plb_pkg: types and constants shared by the positional list buffer files
// no dependencies

package plb_pkg;

  // fixed field widths of the request and result beats
  localparam int unsigned POS_W   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ENTRY_W = 5;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;

  // request codes; the unused code is reported as missing
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } stat_e;

  // what each cell does on a given cycle
  typedef enum logic [1:0] {
    MV_HOLD,
    MV_INSERT,
    MV_REMOVE
  } move_e;

  // broadcast from the control to every cell
  typedef struct packed {
    move_e              op;
    logic [POS_W-1:0]   pos;   // clamped target position
    logic [POS_W-1:0]   cnt;   // entry count before the request
  } plb_ctl_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } plb_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  read_value;
    logic [ENTRY_W-1:0] entry_count;
    logic [DATA_W-1:0]  first_value;
    logic [DATA_W-1:0]  last_value;
  } plb_rsp_t;

endpackage

// ===== rtl/plb_cell.sv =====
// plb_cell: one storage cell of the shifting list
// depends on plb_pkg for the control struct and move codes

module plb_cell import plb_pkg::*; #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  plb_ctl_t             ctl_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  input  logic [WORD_BITS-1:0] value_i,
  output logic [WORD_BITS-1:0] word_o
);

  localparam logic [POS_W-1:0] MyIdx   = POS_W'(IDX);
  localparam logic [POS_W-1:0] NextIdx = POS_W'(IDX + 1);

  logic [WORD_BITS-1:0] word_q, word_d;

  // pick own word, the new word, or a neighbor's word
  always_comb begin
    word_d = word_q;
    case (ctl_i.op)
      MV_INSERT: begin
        if (ctl_i.pos == MyIdx) begin
          word_d = value_i;
        end else if (MyIdx > ctl_i.pos && MyIdx <= ctl_i.cnt) begin
          word_d = left_i;
        end
      end
      MV_REMOVE: begin
        if (MyIdx >= ctl_i.pos && NextIdx < ctl_i.cnt) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== rtl/positional_list_buffer.sv =====
// positional_list_buffer: top level, request control, cell row and result register
// depends on plb_pkg and plb_cell

// Ordered store of up to DEPTH words held in a row of shifting cells. Each
// request beat inserts, removes or reads one word at a position; every
// request gives one result beat with status, the word read or removed, the
// entry count and the first and last words afterwards. When a request is
// taken the cells shift and the word at the position is picked; then, once
// the output register is free, the first and last words are taken from the
// updated row into the output register. A new request is taken only once the
// previous result has entered the output register, so the block cannot take
// a new request while the last one is still in flight. Stack push and pop are
// insert and remove past the end; queue dequeue is remove at position 0.

module positional_list_buffer import plb_pkg::*; #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  plb_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output plb_rsp_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 busy_q;
  stat_e                pend_status_q, pend_status_d;
  logic [WORD_BITS-1:0] pend_got_q, pend_got_d;
  logic                 out_valid_q;
  plb_rsp_t             out_q;

  plb_ctl_t             ctl;
  logic                 accept;
  logic                 advance;
  logic [POS_W-1:0]     cnt_ext;
  logic [POS_W-1:0]     sel_pos;
  logic [WORD_BITS-1:0] in_word;
  logic [WORD_BITS-1:0] sel_word;
  logic [WORD_BITS-1:0] last_word;
  logic [POS_W-1:0]     last_idx;
  logic [WORD_BITS-1:0] cell_word [DEPTH];

  assign accept  = in_valid_i & ~busy_q;
  assign advance = busy_q & (~out_valid_q | ~out_stall_i);
  assign cnt_ext = POS_W'(count_q);
  assign in_word = WORD_BITS'(in_data_i.value);

  // position clamped to the last entry; unchanged for an in-range read
  assign sel_pos = (in_data_i.position > cnt_ext - POS_W'(1)) ? cnt_ext - POS_W'(1)
                                                               : in_data_i.position;

  // decode the request, clamp the position, drive the cell row
  always_comb begin
    ctl.op        = MV_HOLD;
    ctl.pos       = in_data_i.position;
    ctl.cnt       = cnt_ext;
    count_d       = count_q;
    pend_status_d = pend_status_q;
    pend_got_d    = pend_got_q;
    if (accept) begin
      pend_status_d = ST_OK;
      pend_got_d    = '0;
      unique case (in_data_i.req_type)
        REQ_INSERT: begin
          if (count_q == CntFull) begin
            pend_status_d = ST_FULL;
          end else begin
            ctl.op  = MV_INSERT;
            if (in_data_i.position > cnt_ext) ctl.pos = cnt_ext;
            count_d = count_q + CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (count_q == '0) begin
            pend_status_d = ST_MISSING;
          end else begin
            ctl.op     = MV_REMOVE;
            ctl.pos    = sel_pos;
            pend_got_d = sel_word;
            count_d    = count_q - CNT_W'(1);
          end
        end
        REQ_READ: begin
          if (in_data_i.position >= cnt_ext) begin
            pend_status_d = ST_MISSING;
          end else begin
            pend_got_d = sel_word;
          end
        end
        default: pend_status_d = ST_MISSING;
      endcase
    end
  end

  // word at the target position, taken before the row shifts
  always_comb begin
    sel_word = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (sel_pos == POS_W'(i)) sel_word = sel_word | cell_word[i];
    end
  end

  // word at the last position of the updated row
  assign last_idx = cnt_ext - POS_W'(1);
  always_comb begin
    last_word = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (last_idx == POS_W'(i)) last_word = last_word | cell_word[i];
    end
  end

  // row of cells, each fed by its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[g+1];
    end
    plb_cell #(
      .IDX       (g),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .value_i (in_word),
      .word_o  (cell_word[g])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (advance) begin
        busy_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pending result and output beat
  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_got_q    <= pend_got_d;
    if (advance) begin
      out_q.status      <= pend_status_q;
      out_q.read_value  <= DATA_W'(pend_got_q);
      out_q.entry_count <= ENTRY_W'(count_q);
      out_q.first_value <= (count_q != '0) ? DATA_W'(cell_word[0]) : '0;
      out_q.last_value  <= (count_q != '0) ? DATA_W'(last_word) : '0;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/plb_checker.sv =====
// plb_port_checker: port-level assertions for the positional list buffer
// depends on plb_pkg; bound to positional_list_buffer at the end of this file

module plb_port_checker import plb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input plb_req_t in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input plb_rsp_t out_data_o
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // an accepted request blocks the next cycle's request
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  // failed requests carry no word
  a_fail_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.read_value == '0)
    else $error("word reported on failed request");

  // empty store shows zero ends
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_count == '0 |->
      out_data_o.first_value == '0 && out_data_o.last_value == '0)
    else $error("nonzero first or last word on empty store");

endmodule

bind positional_list_buffer plb_port_checker u_plb_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/plb_checker.sv =====
`timescale 1ns / 1ps
// plb_checker: watches the request and result channels of the positional list buffer,
// keeps its own copy of the stored words and compares every result beat
// depends on plb_pkg

module plb_checker import plb_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_stall_i,
  input  plb_req_t req_data_i,
  input  logic     rsp_valid_i,
  input  logic     rsp_stall_i,
  input  plb_rsp_t rsp_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  // mirrored sequence: only entries below held_words are ever looked at
  logic [DATA_W-1:0] seq_words [DEPTH];
  int unsigned       held_words;

  // results still owed by the block, oldest first
  plb_rsp_t owed_rsp_q [$];
  int       fail_total = 0;

  // apply one request to the mirrored sequence and return the result it gives
  function automatic plb_rsp_t apply_request(plb_req_t r);
    plb_rsp_t    res;
    int unsigned at;
    res        = '0;
    res.status = ST_OK;
    at         = 32'(r.position);
    case (r.req_type)
      REQ_INSERT: begin
        if (held_words >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (at > held_words) at = held_words;
          for (int unsigned i = held_words; i > at; i--) seq_words[i] = seq_words[i-1];
          seq_words[at] = r.value;
          held_words++;
        end
      end
      REQ_REMOVE: begin
        if (held_words == 0) begin
          res.status = ST_MISSING;
        end else begin
          if (at > held_words - 1) at = held_words - 1;
          res.read_value = seq_words[at];
          for (int unsigned i = at; i + 1 < held_words; i++) seq_words[i] = seq_words[i+1];
          held_words--;
        end
      end
      REQ_READ: begin
        if (at >= held_words) res.status = ST_MISSING;
        else res.read_value = seq_words[at];
      end
      default: begin
        res.status = ST_MISSING;
      end
    endcase
    res.entry_count = held_words[ENTRY_W-1:0];
    if (held_words != 0) begin
      res.first_value = seq_words[0];
      res.last_value  = seq_words[held_words-1];
    end
    return res;
  endfunction

  // one field of a result beat
  function automatic void check_field(string label, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, seen);
      fail_total++;
    end
  endfunction

  // result beats are checked before the request taken on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    plb_rsp_t want;
    if (!rst_ni) begin
      owed_rsp_q.delete();
      held_words = 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (owed_rsp_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %h", $time, rsp_data_i);
          fail_total++;
        end else begin
          want = owed_rsp_q.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(rsp_data_i.status));
          check_field("read_value", want.read_value, rsp_data_i.read_value);
          check_field("entry_count", DATA_W'(want.entry_count),
                      DATA_W'(rsp_data_i.entry_count));
          check_field("first_value", want.first_value, rsp_data_i.first_value);
          check_field("last_value", want.last_value, rsp_data_i.last_value);
        end
      end
      if (req_valid_i && !req_stall_i) owed_rsp_q.push_back(apply_request(req_data_i));
    end
    fail_count_o <= fail_total;
    pending_o    <= owed_rsp_q.size();
  end

endmodule

// ===== bench/positional_list_buffer_tb.sv =====
`timescale 1ns / 1ps
// positional_list_buffer_tb: clock, reset, request stimulus, result stalls and verdict
// depends on plb_pkg, positional_list_buffer and plb_checker

module positional_list_buffer_tb;
  import plb_pkg::*;

  localparam int unsigned DEPTH = 16;
  // request code the block does not define
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_stall;
  plb_req_t req_data  = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  plb_rsp_t rsp_data;
  int       fail_count;
  int       pending;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int beats_sent = 0;

  always #4 clk_i = ~clk_i;

  positional_list_buffer #(
    .DEPTH     (DEPTH),
    .WORD_BITS (DATA_W)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_data_o  (rsp_data)
  );

  plb_checker #(
    .DEPTH (DEPTH)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_stall_i  (req_stall),
    .req_data_i   (req_data),
    .rsp_valid_i  (rsp_valid),
    .rsp_stall_i  (rsp_stall),
    .rsp_data_i   (rsp_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: long hold-off when requested, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one request beat, with random idle cycles ahead of it
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] where,
                          input logic [DATA_W-1:0] word);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_data  <= '{req_type: kind, position: where, value: word};
    do @(posedge clk_i); while (req_stall);
    beats_sent++;
  endtask

  // random request; queue and stack styles insert and remove only at the ends
  task automatic send_mixed(input int ins_pct, input int style);
    int               roll;
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] where;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) kind = REQ_INSERT;
    else if (roll < ins_pct + (100 - ins_pct) * 3 / 4) kind = REQ_REMOVE;
    else if (roll == 99 && style == 0) kind = REQ_UNUSED;
    else kind = REQ_READ;
    case ($urandom_range(0, 7))
      0: where = '0;
      1: where = '1;
      2: where = POS_W'($urandom_range(0, 255));
      default: where = POS_W'($urandom_range(0, DEPTH + 1));
    endcase
    if (style == 1 && kind == REQ_INSERT) where = '1;
    if (style == 1 && kind == REQ_REMOVE) where = '0;
    if (style == 2 && kind != REQ_READ) where = '1;
    send_req(kind, where, $urandom);
  endtask

  // bursts of varying mix so the store swings between empty and full
  task automatic run_phase(input int idle, input int stall, input int items);
    int goal;
    int style;
    int ins_pct;
    int len;
    idle_pct = idle;
    stall_pct <= stall;
    goal = beats_sent + items;
    while (beats_sent < goal) begin
      style   = $urandom_range(0, 2);
      ins_pct = $urandom_range(20, 80);
      len     = $urandom_range(10, 50);
      repeat (len) if (beats_sent < goal) send_mixed(ins_pct, style);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, unused code, inserts at front, end and middle
    send_req(REQ_READ, '0, '0);
    send_req(REQ_REMOVE, '0, '1);
    send_req(REQ_UNUSED, '1, 32'h5A5A_A5A5);
    send_req(REQ_INSERT, '0, '1);
    send_req(REQ_INSERT, '1, '0);
    send_req(REQ_INSERT, 8'd1, 32'hA5A5_5A5A);
    send_req(REQ_REMOVE, '1, '0);
    send_req(REQ_REMOVE, '0, '0);
    // fill to capacity from both ends and the middle
    for (int k = 0; k < DEPTH - 1; k++) begin
      send_req(REQ_INSERT, (k % 3 == 0) ? 8'd0 : (k % 3 == 1) ? 8'hFF : 8'd7, $urandom);
    end
    send_req(REQ_INSERT, 8'd3, '1);
    send_req(REQ_READ, POS_W'(DEPTH - 1), '0);
    send_req(REQ_READ, POS_W'(DEPTH), '0);
    send_req(REQ_REMOVE, 8'd7, '0);

    run_phase(0, 0, 360);
    run_phase(59, 0, 360);
    run_phase(0, 59, 360);
    run_phase(20, 20, 330);

    // result side held off while requests keep coming, so the input backs up
    idle_pct = 0;
    stall_pct <= 0;
    hold_left <= 60;
    repeat (40) send_mixed(60, 0);

    // drain
    req_valid <= 1'b0;
    stall_pct <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("positional_list_buffer_tb: clean");
    end else begin
      $display("positional_list_buffer_tb: errors");
    end
    $finish;
  end

  // overall limit, far past the slowest correct run
  initial begin
    #3_200_000;
    $display("positional_list_buffer_tb: errors");
    $finish;
  end

endmodule

// ===== positional_list_buffer.f =====
rtl/plb_pkg.sv
rtl/plb_cell.sv
rtl/positional_list_buffer.sv
rtl/plb_checker.sv
bench/plb_checker.sv
bench/positional_list_buffer_tb.sv
